### hdl/rc4_pkg.sv
// Shared types and constants for the RC4 keystream cipher unit.
// No dependencies; rc4_if, rc4_keystream_cipher_unit and rc4_mod import it.
`default_nettype none

package rc4_pkg;

  localparam int BYTE_W = 8;    // key and data byte width
  localparam int LEN_W  = 9;    // state length register width
  localparam int MOD_XW = 10;   // widest sum reduced by the modulo unit
  localparam int MOD_KW = 4;    // shift count of the modulo unit
  localparam int RES_W  = 8;    // remainder width (always below 256)

  localparam logic [LEN_W-1:0] LEN_RESET = 9'd256;
  localparam logic [LEN_W-1:0] LEN_MIN   = 9'd2;

  localparam logic OP_KEY  = 1'b0;
  localparam logic OP_DATA = 1'b1;

  typedef enum logic [4:0] {
    ST_FILL,
    ST_IDLE,
    ST_D_MI,
    ST_D_RI,
    ST_D_MJ0,
    ST_D_MJ,
    ST_D_RJ,
    ST_D_W1,
    ST_D_W2,
    ST_D_MT,
    ST_D_KS,
    ST_D_OUT,
    ST_K_RA,
    ST_K_M0,
    ST_K_MW,
    ST_K_W1,
    ST_K_W2
  } seq_state_t;

  typedef struct packed {
    logic              start;
    logic [MOD_XW-1:0] x;
  } mod_req_t;

endpackage

`default_nettype wire

### hdl/rc4_if.sv
// Valid/ready channel interfaces for the RC4 unit: input beats, result beats
// and the state length write port. Depends on rc4_pkg.
`default_nettype none

interface rc4_in_if import rc4_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              opcode;
  logic [BYTE_W-1:0] in_byte;
  logic              last;

  modport source (output valid, output opcode, output in_byte, output last, input ready);
  modport sink   (input valid, input opcode, input in_byte, input last, output ready);
endinterface

interface rc4_out_if import rc4_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              last_out;

  modport source (output valid, output out_byte, output last_out, input ready);
  modport sink   (input valid, input out_byte, input last_out, output ready);
endinterface

interface rc4_cfg_if import rc4_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [LEN_W-1:0] state_len;

  modport source (output valid, output state_len, input ready);
  modport sink   (input valid, input state_len, output ready);
endinterface

`default_nettype wire

### hdl/rc4_keystream_cipher_unit.sv
// RC4 keystream cipher unit with a programmable permutation length.
//
// Channels: in_ch carries one beat per key byte (opcode 0) or data byte
// (opcode 1); out_ch returns one beat per data byte, the byte XORed with
// the keystream plus a copy of its last flag. Key beats return nothing.
// cfg_ch writes the state length (saturated to 2..MAX_STATE); it is always
// ready and must only be written while the unit is idle.
// A key beat without last set leaves the unit idle, ready for the next beat.
// A key beat with last set starts the key schedule: an identity fill of all
// MAX_STATE entries, then for each of the first state length entries a read,
// a remainder and a swap. A data beat holds in_ch ready low after it is
// accepted and offers its result in the cycle ready returns, so the unit takes
// no new beat before it is through with the last. These steps come from the
// single permutation RAM port and the shared remainder unit; a remainder takes
// one more compare-subtract step per bit that the sum's top bit lies above the
// length's. After reset the unit fills all MAX_STATE permutation entries with
// identity and accepts no beat meanwhile. A result waits in an output register;
// a stalled receiver holds the unit only once the next result is ready to be written.
// Depends on rc4_pkg, rc4_if, rc4_ram and rc4_mod.
`default_nettype none

module rc4_keystream_cipher_unit import rc4_pkg::*; #(
  parameter int MAX_STATE = 256,
  parameter int MAX_KEY   = 256
) (
  input  wire logic clk,
  input  wire logic rst_n,
  rc4_in_if.sink    in_ch,
  rc4_out_if.source out_ch,
  rc4_cfg_if.sink   cfg_ch
);

  localparam int IW = $clog2(MAX_STATE);
  localparam int KW = (MAX_KEY > 1) ? $clog2(MAX_KEY) : 1;
  localparam int CW = $clog2(MAX_KEY + 1);

  seq_state_t state_r, state_nxt;

  logic [LEN_W-1:0]  state_len_r;
  logic [IW-1:0]     gen_i_r, gen_i_nxt;
  logic [IW-1:0]     gen_j_r, gen_j_nxt;
  logic [IW-1:0]     si_r, si_nxt;
  logic [IW-1:0]     a_r, a_nxt;
  logic [IW-1:0]     b_r, b_nxt;
  logic [IW-1:0]     n_r, n_nxt;
  logic [KW-1:0]     kidx_r, kidx_nxt;
  logic [CW-1:0]     key_count_r, key_count_nxt;
  logic              sched_r, sched_nxt;
  logic [BYTE_W-1:0] data_r, data_nxt;
  logic              dlast_r, dlast_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] out_byte_r, out_byte_nxt;
  logic              last_out_r, last_out_nxt;

  logic [LEN_W-1:0]  len;
  logic [IW-1:0]     len_last;
  logic              in_accept;
  logic              out_free;
  logic              key_room;
  logic [BYTE_W-1:0] kb;

  logic              p_we;
  logic [IW-1:0]     p_waddr, p_wdata, p_raddr, p_rdata;
  logic              k_we;
  logic [BYTE_W-1:0] k_rdata;

  mod_req_t          mod_req;
  logic              mod_done;
  logic [RES_W-1:0]  mod_res;

  rc4_ram #(.W(IW), .D(MAX_STATE)) u_perm (
    .clk   (clk),
    .we    (p_we),
    .waddr (p_waddr),
    .wdata (p_wdata),
    .raddr (p_raddr),
    .rdata (p_rdata)
  );

  rc4_ram #(.W(BYTE_W), .D(MAX_KEY)) u_key (
    .clk   (clk),
    .we    (k_we),
    .waddr (key_count_r[KW-1:0]),
    .wdata (in_ch.in_byte),
    .raddr (kidx_r),
    .rdata (k_rdata)
  );

  rc4_mod u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mod_req),
    .len   (len),
    .done  (mod_done),
    .res   (mod_res)
  );

  always_comb begin
    if (state_len_r < LEN_MIN) begin
      len = LEN_MIN;
    end else if (state_len_r > LEN_W'(MAX_STATE)) begin
      len = LEN_W'(MAX_STATE);
    end else begin
      len = state_len_r;
    end
  end

  assign len_last  = IW'(len - LEN_W'(1));
  assign in_accept = in_ch.valid && in_ch.ready;
  assign out_free  = !out_valid_r || out_ch.ready;
  assign key_room  = key_count_r < CW'(MAX_KEY);
  assign k_we      = in_accept && (in_ch.opcode == OP_KEY) && key_room;
  assign kb        = (key_count_r == '0) ? '0 : k_rdata;

  assign in_ch.ready     = (state_r == ST_IDLE);
  assign cfg_ch.ready    = 1'b1;
  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_byte = out_byte_r;
  assign out_ch.last_out = last_out_r;

  always_comb begin
    state_nxt     = state_r;
    gen_i_nxt     = gen_i_r;
    gen_j_nxt     = gen_j_r;
    si_nxt        = si_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    n_nxt         = n_r;
    kidx_nxt      = kidx_r;
    key_count_nxt = key_count_r;
    sched_nxt     = sched_r;
    data_nxt      = data_r;
    dlast_nxt     = dlast_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_byte_nxt  = out_byte_r;
    last_out_nxt  = last_out_r;
    p_we          = 1'b0;
    p_waddr       = '0;
    p_wdata       = '0;
    p_raddr       = '0;
    mod_req       = '0;

    case (state_r)
      ST_FILL: begin
        p_we    = 1'b1;
        p_waddr = n_r;
        p_wdata = n_r;
        n_nxt   = n_r + IW'(1);
        if (n_r == IW'(MAX_STATE - 1)) begin
          if (sched_r) begin
            sched_nxt = 1'b0;
            a_nxt     = '0;
            b_nxt     = '0;
            kidx_nxt  = '0;
            state_nxt = ST_K_RA;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          if (in_ch.opcode == OP_DATA) begin
            data_nxt      = in_ch.in_byte;
            dlast_nxt     = in_ch.last;
            mod_req.start = 1'b1;
            mod_req.x     = MOD_XW'(gen_i_r) + MOD_XW'(1);
            state_nxt     = ST_D_MI;
          end else begin
            if (key_room) begin
              key_count_nxt = key_count_r + CW'(1);
            end
            // A last flag starts the schedule even when the byte was dropped.
            if (in_ch.last) begin
              sched_nxt = 1'b1;
              n_nxt     = '0;
              state_nxt = ST_FILL;
            end
          end
        end
      end
      ST_D_MI: begin
        if (mod_done) begin
          gen_i_nxt = IW'(mod_res);
          state_nxt = ST_D_RI;
        end
      end
      ST_D_RI: begin
        p_raddr   = gen_i_r;
        state_nxt = ST_D_MJ0;
      end
      ST_D_MJ0: begin
        si_nxt        = p_rdata;
        mod_req.start = 1'b1;
        mod_req.x     = MOD_XW'(gen_j_r) + MOD_XW'(p_rdata);
        state_nxt     = ST_D_MJ;
      end
      ST_D_MJ: begin
        if (mod_done) begin
          gen_j_nxt = IW'(mod_res);
          state_nxt = ST_D_RJ;
        end
      end
      ST_D_RJ: begin
        p_raddr   = gen_j_r;
        state_nxt = ST_D_W1;
      end
      ST_D_W1: begin
        // Swap the two entries while the keystream index is reduced.
        p_we          = 1'b1;
        p_waddr       = gen_i_r;
        p_wdata       = p_rdata;
        mod_req.start = 1'b1;
        mod_req.x     = MOD_XW'(si_r) + MOD_XW'(p_rdata);
        state_nxt     = ST_D_W2;
      end
      ST_D_W2: begin
        p_we      = 1'b1;
        p_waddr   = gen_j_r;
        p_wdata   = si_r;
        state_nxt = ST_D_MT;
      end
      ST_D_MT: begin
        if (mod_done) begin
          p_raddr   = IW'(mod_res);
          state_nxt = ST_D_KS;
        end
      end
      ST_D_KS: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = data_r ^ BYTE_W'(p_rdata);
          last_out_nxt  = dlast_r;
          state_nxt     = ST_IDLE;
        end else begin
          data_nxt  = data_r ^ BYTE_W'(p_rdata);
          state_nxt = ST_D_OUT;
        end
      end
      ST_D_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = data_r;
          last_out_nxt  = dlast_r;
          state_nxt     = ST_IDLE;
        end
      end
      ST_K_RA: begin
        p_raddr   = a_r;
        state_nxt = ST_K_M0;
      end
      ST_K_M0: begin
        si_nxt        = p_rdata;
        mod_req.start = 1'b1;
        mod_req.x     = MOD_XW'(b_r) + MOD_XW'(p_rdata) + MOD_XW'(kb);
        state_nxt     = ST_K_MW;
      end
      ST_K_MW: begin
        if (mod_done) begin
          b_nxt     = IW'(mod_res);
          p_raddr   = IW'(mod_res);
          state_nxt = ST_K_W1;
        end
      end
      ST_K_W1: begin
        p_we      = 1'b1;
        p_waddr   = a_r;
        p_wdata   = p_rdata;
        state_nxt = ST_K_W2;
      end
      ST_K_W2: begin
        p_we    = 1'b1;
        p_waddr = b_r;
        p_wdata = si_r;
        if (a_r == len_last) begin
          gen_i_nxt     = '0;
          gen_j_nxt     = '0;
          key_count_nxt = '0;
          state_nxt     = ST_IDLE;
        end else begin
          a_nxt = a_r + IW'(1);
          // The key bytes are used cyclically over the bytes held.
          if (CW'(kidx_r) + CW'(1) == key_count_r) begin
            kidx_nxt = '0;
          end else begin
            kidx_nxt = kidx_r + KW'(1);
          end
          state_nxt = ST_K_RA;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_FILL;
      state_len_r <= LEN_RESET;
      gen_i_r     <= '0;
      gen_j_r     <= '0;
      n_r         <= '0;
      key_count_r <= '0;
      sched_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      gen_i_r     <= gen_i_nxt;
      gen_j_r     <= gen_j_nxt;
      n_r         <= n_nxt;
      key_count_r <= key_count_nxt;
      sched_r     <= sched_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        state_len_r <= cfg_ch.state_len;
      end
    end
  end

  always_ff @(posedge clk) begin
    si_r       <= si_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    kidx_r     <= kidx_nxt;
    data_r     <= data_nxt;
    dlast_r    <= dlast_nxt;
    out_byte_r <= out_byte_nxt;
    last_out_r <= last_out_nxt;
  end

  // The remainder unit only finishes in a state that waits for it.
  a_mod_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    mod_done |-> (state_r == ST_D_MI || state_r == ST_D_MJ ||
                  state_r == ST_D_MT || state_r == ST_K_MW))
    else $error("remainder result arrived outside a wait state");

  a_last_key_schedules: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_ch.opcode == OP_KEY && in_ch.last) |=>
      (state_r == ST_FILL && sched_r))
    else $error("last key beat did not start the key schedule");

  a_key_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    key_count_r <= CW'(MAX_KEY))
    else $error("key count beyond key store depth");

  a_no_accept_in_schedule: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_K_W2 && a_r != len_last) |=> !in_ch.ready)
    else $error("input accepted in the middle of the key schedule");

endmodule

`default_nettype wire

### hdl/rc4_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module rc4_ram #(
  parameter int W = 8,
  parameter int D = 256
) (
  input  wire logic                              clk,
  input  wire logic                              we,
  input  wire logic [((D > 1) ? $clog2(D) : 1)-1:0] waddr,
  input  wire logic [W-1:0]                      wdata,
  input  wire logic [((D > 1) ? $clog2(D) : 1)-1:0] raddr,
  output logic      [W-1:0]                      rdata
);

  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_r;

  // Read returns the old contents when the same address is written.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### hdl/rc4_mod.sv
// Shared remainder unit: reduces a sum modulo the state length by restoring
// subtraction, one shifted compare-subtract per cycle. Depends on rc4_pkg.
`default_nettype none

module rc4_mod import rc4_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire mod_req_t         req,
  input  wire logic [LEN_W-1:0] len,
  output logic                  done,
  output logic      [RES_W-1:0] res
);

  localparam int MOD_DW = MOD_XW + LEN_W - 1;

  logic [MOD_XW-1:0] x_r, x_nxt;
  logic [MOD_KW-1:0] k_r, k_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;

  logic [MOD_KW-1:0] mx, ml, k_start;
  logic [MOD_DW-1:0] d_sh, x_wide;

  function automatic logic [MOD_KW-1:0] msb_pos(input logic [MOD_XW-1:0] v);
    logic [MOD_KW-1:0] p;
    p = '0;
    for (int i = 0; i < MOD_XW; i++) begin
      if (v[i]) begin
        p = MOD_KW'(i);
      end
    end
    return p;
  endfunction

  // The first step lines the divisor's top bit up with the sum's top bit.
  always_comb begin
    mx      = msb_pos(req.x);
    ml      = msb_pos(MOD_XW'(len));
    k_start = (mx > ml) ? (mx - ml) : '0;
  end

  always_comb begin
    d_sh     = MOD_DW'(len) << k_r;
    x_wide   = MOD_DW'(x_r);
    x_nxt    = x_r;
    k_nxt    = k_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      x_nxt    = req.x;
      k_nxt    = k_start;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (x_wide >= d_sh) begin
        x_nxt = MOD_XW'(x_wide - d_sh);
      end
      if (k_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        k_nxt = k_r - MOD_KW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    k_r <= k_nxt;
  end

  assign done = done_r;
  assign res  = x_r[RES_W-1:0];

endmodule

`default_nettype wire
